>>> hdl/stmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stmf_pkg
// Shared constants, types and sequencer states for the sliding trimmed mean
// filter.
// ----------------------------------------------------------------------------
package stmf_pkg;

   localparam int SAMPLE_W       = 24;
   localparam int WINDOW_LEN     = 10;
   localparam int TRIM_EACH_SIDE = 2;

   // trim is clamped so at least one value always survives
   localparam int TRIM_LIMIT = (WINDOW_LEN - 1) / 2;
   localparam int EFF_TRIM   = (TRIM_EACH_SIDE > TRIM_LIMIT) ? TRIM_LIMIT : TRIM_EACH_SIDE;
   localparam int KEPT       = WINDOW_LEN - 2 * EFF_TRIM;

   localparam int SLOT_W = $clog2(WINDOW_LEN);
   localparam int RANK_W = $clog2(WINDOW_LEN + 1);
   localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_LEN + 1);

   // reciprocal of the kept count, scaled by 2^RECIP_SHIFT (rounded down)
   localparam int RECIP_SHIFT = 32;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((65'd1 << RECIP_SHIFT) / KEPT);

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef sample_type                 window_type [WINDOW_LEN];
   typedef logic signed [SUM_W-1:0]    sum_type;
   typedef logic [SLOT_W-1:0]          slot_type;
   typedef logic [RANK_W-1:0]          rank_type;

   typedef struct packed {
      logic       keep;
      sample_type value;
   } rank_info_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RANK,
      ST_DIV,
      ST_OUT
   } state_type;

endpackage

>>> hdl/stmf_rank_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stmf_rank_unit
// Shared rank unit: finds the sorted position of one window entry against
// the whole window and flags whether it lies in the kept middle band.
// ----------------------------------------------------------------------------
module stmf_rank_unit (
   input  stmf_pkg::window_type    window,
   input  stmf_pkg::slot_type      index,
   output stmf_pkg::rank_info_type info
);

   stmf_pkg::sample_type              cand;
   logic [stmf_pkg::WINDOW_LEN-1:0]   below;
   stmf_pkg::rank_type                rank;

   assign cand = window[index];

   // ties are broken by position so every entry gets a distinct rank
   always_comb begin
      for (int j = 0; j < stmf_pkg::WINDOW_LEN; j++) begin
         below[j] = (window[j] < cand) ||
                    ((window[j] == cand) && (stmf_pkg::SLOT_W'(j) < index));
      end
   end

   assign rank = stmf_pkg::RANK_W'($countones(below));

   assign info.value = cand;
   assign info.keep  = (rank >= stmf_pkg::RANK_W'(stmf_pkg::EFF_TRIM)) &&
                       (rank <  stmf_pkg::RANK_W'(stmf_pkg::WINDOW_LEN - stmf_pkg::EFF_TRIM));

endmodule

>>> hdl/stmf_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stmf_divider
// Three-stage divide of the kept sum by the kept count, truncating toward
// zero: reciprocal multiply, one-step correction, sign restore.
// ----------------------------------------------------------------------------
module stmf_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  stmf_pkg::sum_type    sum,
   output logic                 done,
   output stmf_pkg::sample_type quotient
);

   localparam int PROD_W = stmf_pkg::SUM_W + stmf_pkg::RECIP_W;

   logic [2:0]                   valid_ff;
   logic [2:0]                   valid_in;
   logic [stmf_pkg::SUM_W-1:0]   mag_in;
   logic [stmf_pkg::SUM_W-1:0]   mag_ff;
   logic [2:0]                   neg_ff;
   logic [PROD_W-1:0]            prod;
   logic [stmf_pkg::SUM_W-1:0]   est_in;
   logic [stmf_pkg::SUM_W-1:0]   est_ff;
   logic [stmf_pkg::SUM_W-1:0]   rem;
   logic [stmf_pkg::SUM_W-1:0]   fix_in;
   logic [stmf_pkg::SUM_W-1:0]   fix_ff;
   stmf_pkg::sample_type         quot_in;

   assign valid_in = {valid_ff[1:0], start};
   assign mag_in   = sum[stmf_pkg::SUM_W-1] ? stmf_pkg::SUM_W'(-sum) : stmf_pkg::SUM_W'(sum);

   // stage 1: estimate is at most one below the true quotient
   assign prod   = PROD_W'(mag_ff) * PROD_W'(stmf_pkg::RECIP);
   assign est_in = prod[stmf_pkg::RECIP_SHIFT +: stmf_pkg::SUM_W];

   // stage 2: correct the estimate
   assign rem    = mag_ff - stmf_pkg::SUM_W'(est_ff * stmf_pkg::SUM_W'(stmf_pkg::KEPT));
   assign fix_in = (rem >= stmf_pkg::SUM_W'(stmf_pkg::KEPT)) ? est_ff + 1'b1 : est_ff;

   // stage 3: restore sign
   assign quot_in = neg_ff[2] ? stmf_pkg::SAMPLE_W'(-fix_ff) : stmf_pkg::SAMPLE_W'(fix_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mag_ff    <= mag_in;
         neg_ff[0] <= sum[stmf_pkg::SUM_W-1];
      end
      if (valid_ff[0]) begin
         est_ff    <= est_in;
         neg_ff[1] <= neg_ff[0];
      end
      if (valid_ff[1]) begin
         fix_ff    <= fix_in;
         neg_ff[2] <= neg_ff[1];
      end
   end

   // mag_ff stays valid through stage 2 since a new start cannot arrive yet
   assign done     = valid_ff[2];
   assign quotient = quot_in;

endmodule

>>> hdl/sliding_trimmed_mean_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_trimmed_mean_filter
// Ten-entry sliding window; mean of the middle six values after dropping the
// two lowest and two highest, truncated toward zero.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel req_valid/req_stall/req_sample carries one signed sample
//   per transaction. The sample replaces the oldest window entry.
//   Result channel rsp_valid/rsp_stall/rsp_filtered carries one result per
//   input transaction, in order.
//   Processing: after a transaction is taken, a shared rank unit visits each
//   of the ten window entries, one per cycle, and accumulates the kept ones.
//   A three-stage reciprocal divider then forms the mean, and the result
//   enters the output register, which also raises rsp_valid.
//   req_stall is high from accept until the result is in the output
//   register. A stalled result is held there; the next item may be taken
//   meanwhile and waits at the end of its work for the register to free.
//   Reset (synchronous, active high) zeroes the window and the write slot
//   and drops any pending result.
// ----------------------------------------------------------------------------
module sliding_trimmed_mean_filter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  stmf_pkg::sample_type req_sample,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output stmf_pkg::sample_type rsp_filtered
);

   stmf_pkg::state_type     state_ff;
   stmf_pkg::state_type     state_in;
   stmf_pkg::window_type    window_ff;
   stmf_pkg::slot_type      slot_ff;
   stmf_pkg::slot_type      slot_in;
   stmf_pkg::slot_type      idx_ff;
   stmf_pkg::slot_type      idx_in;
   stmf_pkg::sum_type       sum_ff;
   stmf_pkg::sum_type       sum_in;
   stmf_pkg::rank_info_type info;
   stmf_pkg::sample_type    quotient;
   stmf_pkg::sample_type    result_ff;
   stmf_pkg::sample_type    rsp_filtered_ff;
   logic                    rsp_valid_ff;
   logic                    req_take;
   logic                    last_idx;
   logic                    div_start;
   logic                    div_done;
   logic                    load_rsp;

   assign req_take = req_valid && !req_stall;
   assign last_idx = (idx_ff == stmf_pkg::SLOT_W'(stmf_pkg::WINDOW_LEN - 1));

   stmf_rank_unit u_rank (
      .window (window_ff),
      .index  (idx_ff),
      .info   (info)
   );

   stmf_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .sum      (sum_in),
      .done     (div_done),
      .quotient (quotient)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         stmf_pkg::ST_IDLE: if (req_take) state_in = stmf_pkg::ST_RANK;
         stmf_pkg::ST_RANK: if (last_idx) state_in = stmf_pkg::ST_DIV;
         stmf_pkg::ST_DIV:  if (div_done) state_in = stmf_pkg::ST_OUT;
         stmf_pkg::ST_OUT:  if (!rsp_valid_ff || !rsp_stall) state_in = stmf_pkg::ST_IDLE;
         default:           state_in = stmf_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      div_start = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         stmf_pkg::ST_IDLE: req_stall = 1'b0;
         stmf_pkg::ST_RANK: div_start = last_idx;
         stmf_pkg::ST_DIV:  ;
         stmf_pkg::ST_OUT:  load_rsp = !rsp_valid_ff || !rsp_stall;
         default:           ;
      endcase
   end

   assign slot_in = (slot_ff == stmf_pkg::SLOT_W'(stmf_pkg::WINDOW_LEN - 1)) ? '0 : slot_ff + 1'b1;
   assign idx_in  = (state_ff == stmf_pkg::ST_RANK && !last_idx) ? idx_ff + 1'b1 : '0;
   assign sum_in  = info.keep ? sum_ff + stmf_pkg::SUM_W'(info.value) : sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stmf_pkg::ST_IDLE;
         slot_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < stmf_pkg::WINDOW_LEN; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (req_take) begin
            window_ff[slot_ff] <= req_sample;
            slot_ff            <= slot_in;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         sum_ff <= '0;
      end else if (state_ff == stmf_pkg::ST_RANK) begin
         sum_ff <= sum_in;
      end
      if (div_done) begin
         result_ff <= quotient;
      end
      if (load_rsp) begin
         rsp_filtered_ff <= result_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;

endmodule
